// File: rtl/core/rcs_pkg.sv
// package for the radial cone stamp pixel block
// widths, reset value and size limit; no dependencies
package rcs_pkg;
  localparam int unsigned MaxSizeDefault = 1024;
  localparam int unsigned SizeW = 11;
  localparam int unsigned CoordW = 10;
  localparam int unsigned HeightW = 17;
  localparam logic [SizeW-1:0] SizeReset = 11'd256;
endpackage

// File: rtl/core/radial_cone_stamp_pixel_top.sv
// Cone height of a pixel in a square stamp: one request per cycle, fully pipelined.
// Pipeline stages in order, with HW the bit width of half:
// one stage for the squared distance, QN = (HW+17)/2 square-root stages of two root bits,
// one stage to form the dividend, SN = HW+17 restoring divide stages, and an output stage.
// A result that waits at the output holds the whole pipeline and the request side. Uses rcs_pkg.
module radial_cone_stamp_pixel_top
  import rcs_pkg::*;
#(
  parameter int unsigned MAX_SIZE = MaxSizeDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CoordW-1:0]  row_i,
  input  logic [CoordW-1:0]  column_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HeightW-1:0] height_o,
  output logic               inside_res_o
);
  localparam int unsigned HW = $clog2(MAX_SIZE/2 + 1);   // bits of half
  localparam int unsigned DW = 2*HW;                      // bits of d2 inside the circle
  localparam int unsigned QN = (HW + 17) / 2;             // square root stages
  localparam int unsigned RB = 2*QN;                      // bits of r, U.16
  localparam int unsigned TB = 2*RB;                      // radicand bits
  localparam int unsigned NW = HW + 17;                   // dividend width
  localparam int unsigned SN = NW;                        // divide steps
  localparam int unsigned PN = QN + SN + 2;               // valid pipeline length

  logic [SizeW-1:0] size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeReset;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end
  logic [SizeW-1:0] size_sat;
  logic [HW-1:0]    half;
  assign size_sat = (32'(size_q) > MAX_SIZE) ? SizeW'(MAX_SIZE) : size_q;
  assign half = HW'(size_sat >> 1);

  logic adv;
  // pipeline moves when the output stage can take
  logic skid_v_q;
  assign adv = !skid_v_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 0: squared distance
  logic signed [CoordW+1:0] dx, dy;
  logic signed [2*CoordW+3:0] dxw, dyw, dxsq, dysq;
  logic [2*CoordW+3:0] d2f;
  logic [2*HW-1:0] hh;
  logic in_circle;
  assign dx = $signed({2'b0, column_i}) - $signed((CoordW+2)'(half));
  assign dy = $signed({2'b0, row_i}) - $signed((CoordW+2)'(half));
  assign dxw = (2*CoordW+4)'(dx);
  assign dyw = (2*CoordW+4)'(dy);
  assign dxsq = dxw * dxw;
  assign dysq = dyw * dyw;
  assign d2f = unsigned'(dxsq) + unsigned'(dysq);
  assign hh = half * half;
  assign in_circle = (half != '0) && (d2f < (2*CoordW+4)'(hh));

  logic [PN-1:0]   sq_v_q;
  logic [PN-1:0]   sq_in_q;
  logic [TB-1:0]   sq_x_q [QN+1];
  logic [RB-1:0]   sq_r_q [QN+1];
  logic [RB+1:0]   sq_m_q [QN+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= '0;
    else if (adv) sq_v_q <= {sq_v_q[PN-2:0], in_valid_i};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_in_q <= {sq_in_q[PN-2:0], in_circle};
      // radicand is d2 * 2^32, d2 below hh when inside
      sq_x_q[0] <= TB'({d2f[DW-1:0], 32'b0});
      sq_r_q[0] <= '0;
      sq_m_q[0] <= '0;
    end
  end

  // square root of d2 * 2^32, digit by digit, two root bits per stage
  for (genvar k = 0; k < QN; k++) begin : g_sq
    logic [TB-1:0] x;
    logic [RB-1:0] r;
    logic [RB+1:0] m;
    always_comb begin
      x = sq_x_q[k];
      r = sq_r_q[k];
      m = sq_m_q[k];
      for (int j = 0; j < 2; j++) begin
        m = {m[RB-1:0], x[TB-1 -: 2]};
        x = x << 2;
        if (m >= {r, 2'b01}) begin
          m = m - {r, 2'b01};
          r = {r[RB-2:0], 1'b1};
        end else begin
          r = {r[RB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_x_q[k+1] <= x;
        sq_r_q[k+1] <= r;
        sq_m_q[k+1] <= m;
      end
    end
  end

  // divide (half*2^16 - r) / half, restoring, one quotient bit per stage
  logic [NW-1:0] dv_n_q [SN+1];
  logic [NW-1:0] dv_q_q [SN+1];
  logic [HW:0]   dv_p_q [SN+1];
  logic [HW-1:0] dv_h_q [SN+1];
  logic [NW-1:0] hs, rs;
  assign hs = NW'({half, 16'b0});
  assign rs = NW'(sq_r_q[QN]);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_n_q[0] <= (hs > rs) ? hs - rs : '0;
      dv_q_q[0] <= '0;
      dv_p_q[0] <= '0;
      dv_h_q[0] <= half;
    end
  end
  for (genvar k = 0; k < SN; k++) begin : g_dv
    logic [HW+1:0] t;
    assign t = {dv_p_q[k], dv_n_q[k][NW-1]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_n_q[k+1] <= dv_n_q[k] << 1;
        dv_h_q[k+1] <= dv_h_q[k];
        if (t >= (HW+2)'(dv_h_q[k])) begin
          dv_p_q[k+1] <= (HW+1)'(t - (HW+2)'(dv_h_q[k]));
          dv_q_q[k+1] <= {dv_q_q[k][NW-2:0], 1'b1};
        end else begin
          dv_p_q[k+1] <= (HW+1)'(t);
          dv_q_q[k+1] <= {dv_q_q[k][NW-2:0], 1'b0};
        end
      end
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skid_v_q <= 1'b0;
    else if (adv) skid_v_q <= sq_v_q[PN-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inside_res_o <= sq_in_q[PN-1];
      height_o <= sq_in_q[PN-1] ? HeightW'(dv_q_q[SN]) : '0;
    end
  end
  assign out_valid_o = skid_v_q;
endmodule

// File: verif/rcs_checker.sv
// checker for the radial cone stamp block: watches both channels, predicts cone heights
// and compares them in order; depends on rcs_pkg
module rcs_checker
  import rcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [CoordW-1:0]  row_i,
  input  logic [CoordW-1:0]  column_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [HeightW-1:0] height_i,
  input  logic               inside_res_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [HeightW-1:0] height;
    logic               in_circle;
  } cone_t;

  logic [SizeW-1:0] size_q;
  cone_t heights_q[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic cone_t cone_height(logic [SizeW-1:0] sz, logic [CoordW-1:0] row,
                                        logic [CoordW-1:0] col);
    longint half, dx, dy;
    logic [63:0] d2, r;
    cone_t c;
    longint eff;
    eff = (sz > MaxSizeDefault) ? MaxSizeDefault : sz;
    half = eff >> 1;
    dy = longint'(row) - half;
    dx = longint'(col) - half;
    d2 = dx * dx + dy * dy;
    c = '0;
    if (half > 0 && d2 < half * half) begin
      c.in_circle = 1'b1;
      r = root64(d2 << 32);
      c.height = HeightW'(((64'(half) << 16) - r) / 64'(half));
    end
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    cone_t e;
    if (!rst_ni) begin
      size_q <= SizeReset;
      fail_count_o <= 0;
      heights_q.delete();
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) heights_q.push_back(cone_height(size_q, row_i, column_i));
      if (out_valid_i && out_ready_i) begin
        if (heights_q.size() == 0) begin
          $display("%0t: unexpected result height %0d inside %0d", $time, height_i,
                   inside_res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = heights_q.pop_front();
          if (e.height !== height_i || e.in_circle !== inside_res_i) begin
            $display("%0t: expected height %0d inside %0d, actual height %0d inside %0d",
                     $time, e.height, e.in_circle, height_i, inside_res_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = heights_q.size();
endmodule

// File: verif/tb.sv
// testbench top for radial_cone_stamp_pixel_top: drives pixel requests and size writes
// with random idling; depends on rcs_pkg and rcs_checker
module tb;
  import rcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CoordW-1:0] row_i = '0;
  logic [CoordW-1:0] column_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [HeightW-1:0] height_o;
  logic inside_res_o;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm;

  always #10 clk_i = ~clk_i;

  radial_cone_stamp_pixel_top i_dut (.*);

  rcs_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o),
    .row_i, .column_i, .out_valid_i(out_valid_o), .out_ready_i, .height_i(height_o),
    .inside_res_i(inside_res_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // random stall on the result side, none while calm
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 32);

  // watchdog on cycles with no accepted request, result or size write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(logic [CoordW-1:0] row, logic [CoordW-1:0] col);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i <= row;
    column_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_size(logic [SizeW-1:0] sz);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // pixels mostly inside the stamp, some beyond it
  task automatic random_pixels(int n, int sz);
    int lim;
    lim = (sz > 1) ? ((sz > 1024) ? 1023 : sz - 1) : 1023;
    repeat (n) begin
      if ($urandom_range(9) == 0) send_pixel(CoordW'($urandom), CoordW'($urandom));
      else send_pixel(CoordW'($urandom_range(lim)), CoordW'($urandom_range(lim)));
    end
  endtask

  initial begin
    int sizes[8] = '{1024, 0, 1, 2, 3, 2047, 17, 1025};
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset size 256: center, corners, edges, just inside and outside the rim
    send_pixel(10'd128, 10'd128);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd128, 10'd0);
    send_pixel(10'd128, 10'd1);
    send_pixel(10'd1, 10'd128);
    send_pixel(10'd128, 10'd255);
    send_pixel(10'd255, 10'd255);
    send_pixel(10'd129, 10'd129);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    random_pixels(150, 256);
    foreach (sizes[k]) begin
      write_size(SizeW'(sizes[k]));
      send_pixel(CoordW'(sizes[k] / 2), CoordW'(sizes[k] / 2));
      send_pixel(10'd0, CoordW'(sizes[k] / 2));
      calm = (k == 3);
      random_pixels((sizes[k] == 1024 || sizes[k] == 17) ? 200 : 80, sizes[k]);
      calm = 1'b0;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
